>>> design/csem_pkg.sv
// Shared types, constants and helper functions for the counting semaphore table.
// Used by csem_name_ram users, csem_ctrl, counting_semaphore_table and csem_checker.
// Depends on nothing.
package csem_pkg;

    // Table sizing.
    localparam int NUM_SEMS    = 32;
    localparam int NAME_BYTES  = 32;
    localparam int COUNT_BITS  = 16;
    localparam int WAITER_BITS = 8;

    localparam int SLOT_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int NAME_WORDS = 4;
    localparam int WORD_W     = 2;
    localparam int RAM_DEPTH  = NUM_SEMS * NAME_WORDS;
    localparam int RAM_AW     = SLOT_W + WORD_W;

    // Fixed field widths of the stream words.
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 5;
    localparam int NWORD_W  = 64;
    localparam int LEN_W    = 6;
    localparam int INIT_W   = 16;
    localparam int STATUS_W = 3;

    localparam int IN_BITS   = ID_W + NAME_WORDS * NWORD_W + LEN_W + INIT_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STATUS_W + ID_W + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam longint unsigned COUNT_MAX_L = (64'd1 << COUNT_BITS) - 64'd1;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_OPEN    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLOSE   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef logic [NAME_WORDS-1:0][NWORD_W-1:0] t_name;

    // One request word as unpacked from the input stream.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   sem_id;
        t_name             name;
        logic [LEN_W-1:0]  name_length;
        logic [INIT_W-1:0] initial_count;
    } t_item;

    // One response word.
    typedef struct packed {
        logic          created;
        logic          woke_waiter;
        logic [ID_W-1:0] sem_id_out;
        logic [STATUS_W-1:0] status;
    } t_result;

    // Byte mask of one name word for a name of len bytes.
    function automatic logic [NWORD_W-1:0] word_mask(logic [LEN_W-1:0] len, int w);
        logic [NWORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (7'(len) > 7'(w * 8 + b)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> design/csem_name_ram.sv
// Single-port name store with registered read data.
// Generic RAM; depends on nothing.
module csem_name_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/csem_ctrl.sv
// Sequencer of the semaphore table: holds the per-slot state and runs one
// request at a time, scanning names through a shared 64-bit word compare.
// Depends on csem_pkg; drives the name RAM ports of csem_name_ram.
module csem_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  csem_pkg::t_item            i_item,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output csem_pkg::t_result          o_res,
    output logic                       o_ram_we,
    output logic [csem_pkg::RAM_AW-1:0] o_ram_addr,
    output logic [csem_pkg::NWORD_W-1:0] o_ram_wdata,
    input  logic [csem_pkg::NWORD_W-1:0] i_ram_rdata
);
    import csem_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SEMS - 1);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(NAME_WORDS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [WAITER_BITS-1:0] WAIT_MAX = '1;

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_free_vld, n_free_vld;
    logic [SLOT_W-1:0] r_free_slot, n_free_slot;
    t_result           r_res, n_res;
    t_item             r_item;

    // Per-slot state.
    logic                   r_in_use [NUM_SEMS];
    logic [LEN_W-1:0]       r_len    [NUM_SEMS];
    logic [COUNT_BITS-1:0]  r_cnt    [NUM_SEMS];
    logic [WAITER_BITS-1:0] r_wait   [NUM_SEMS];

    // Request captured at accept: clamped length and masked name.
    logic [LEN_W-1:0] in_len;
    t_name            in_name;
    t_item            in_item;

    always_comb begin
        in_len = i_item.name_length;
        if (in_len > LEN_W'(NAME_BYTES)) begin
            in_len = LEN_W'(NAME_BYTES);
        end
        for (int w = 0; w < NAME_WORDS; w++) begin
            in_name[w] = i_item.name[w] & word_mask(in_len, w);
        end
        in_item             = i_item;
        in_item.name        = in_name;
        in_item.name_length = in_len;
    end

    // Lookups of the addressed slot.
    logic [SLOT_W-1:0]      id_idx;
    logic                   id_ok;
    logic                   slot_used;
    logic                   word_eq;
    logic                   init_sat;
    logic [COUNT_BITS-1:0]  init_cnt;

    assign id_idx    = SLOT_W'(r_item.sem_id);
    assign id_ok     = (32'(r_item.sem_id) < 32'(NUM_SEMS)) && r_in_use[id_idx];
    assign slot_used = r_in_use[r_slot];
    assign word_eq   = (i_ram_rdata == r_item.name[r_word]);
    assign init_sat  = (64'(r_item.initial_count) > COUNT_MAX_L);
    assign init_cnt  = init_sat ? CNT_MAX : COUNT_BITS'(r_item.initial_count);

    // Table update strobes.
    logic                   open_commit;
    logic                   cnt_we, wait_we, use_clr;
    logic [COUNT_BITS-1:0]  cnt_val;
    logic [WAITER_BITS-1:0] wait_val;
    logic                   no_match_end;
    logic                   have_free;
    logic [SLOT_W-1:0]      free_slot;

    // Sequencer next state and shared compare.
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_word      = r_word;
        n_free_vld  = r_free_vld;
        n_free_slot = r_free_slot;
        n_res       = r_res;
        o_ram_we    = 1'b0;
        o_ram_addr  = {r_slot, r_word};
        o_ram_wdata = r_item.name[r_word];
        open_commit = 1'b0;
        cnt_we      = 1'b0;
        wait_we     = 1'b0;
        use_clr     = 1'b0;
        cnt_val     = r_cnt[id_idx];
        wait_val    = r_wait[id_idx];
        no_match_end = 1'b0;
        have_free   = r_free_vld;
        free_slot   = r_free_slot;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_slot     = '0;
                    n_word     = '0;
                    n_free_vld = 1'b0;
                    n_res      = '{created: 1'b0, woke_waiter: 1'b0,
                                   sem_id_out: i_item.sem_id, status: ST_OK};
                    n_state    = (i_item.func == FN_OPEN) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if (slot_used && (r_len[r_slot] == r_item.name_length)) begin
                    // Candidate: start reading its first name word.
                    o_ram_addr = {r_slot, {WORD_W{1'b0}}};
                    n_word     = '0;
                    n_state    = S_CMP;
                end else begin
                    if (!slot_used && !r_free_vld) begin
                        n_free_vld  = 1'b1;
                        n_free_slot = r_slot;
                        have_free   = 1'b1;
                        free_slot   = r_slot;
                    end
                    if (r_slot == LAST_SLOT) begin
                        no_match_end = 1'b1;
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (word_eq) begin
                    if (r_word == LAST_WORD) begin
                        n_res.sem_id_out = ID_W'(r_slot);
                        n_state = S_DONE;
                    end else begin
                        o_ram_addr = {r_slot, r_word + 1'b1};
                        n_word     = r_word + 1'b1;
                    end
                end else if (r_slot == LAST_SLOT) begin
                    no_match_end = 1'b1;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_WRITE: begin
                o_ram_we = 1'b1;
                n_word   = r_word + 1'b1;
                if (r_word == LAST_WORD) begin
                    open_commit      = 1'b1;
                    n_res.created    = 1'b1;
                    n_res.sem_id_out = ID_W'(r_slot);
                    n_res.status     = init_sat ? ST_OVERFLOW : ST_OK;
                    n_state          = S_DONE;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (!id_ok) begin
                    n_res.status = ST_BAD_ID;
                end else begin
                    case (r_item.func)
                        FN_ACQUIRE: begin
                            if (r_cnt[id_idx] != '0) begin
                                cnt_we  = 1'b1;
                                cnt_val = r_cnt[id_idx] - 1'b1;
                            end else if (r_wait[id_idx] == WAIT_MAX) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                wait_we      = 1'b1;
                                wait_val     = r_wait[id_idx] + 1'b1;
                                n_res.status = ST_BLOCKED;
                            end
                        end
                        FN_RELEASE: begin
                            if (r_wait[id_idx] != '0) begin
                                wait_we           = 1'b1;
                                wait_val          = r_wait[id_idx] - 1'b1;
                                n_res.woke_waiter = 1'b1;
                            end else if (r_cnt[id_idx] == CNT_MAX) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                cnt_we  = 1'b1;
                                cnt_val = r_cnt[id_idx] + 1'b1;
                            end
                        end
                        FN_CLOSE: begin
                            use_clr  = 1'b1;
                            wait_we  = 1'b1;
                            wait_val = '0;
                        end
                        default: begin
                            n_res.status = ST_BAD_ID;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a scan with no name match: create in a free slot or report full.
        if (no_match_end) begin
            if (have_free) begin
                n_slot  = free_slot;
                n_word  = '0;
                n_state = S_WRITE;
            end else begin
                n_res.status = ST_FULL;
                n_state      = S_DONE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_free_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_vld <= n_free_vld;
        end
    end

    // Working registers and request capture.
    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_word      <= n_word;
        r_free_slot <= n_free_slot;
        r_res       <= n_res;
        if (r_state == S_IDLE && i_valid) begin
            r_item <= in_item;
        end
    end

    // In-use flags clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SEMS; s++) begin
                r_in_use[s] <= 1'b0;
            end
        end else if (open_commit) begin
            r_in_use[r_slot] <= 1'b1;
        end else if (use_clr) begin
            r_in_use[id_idx] <= 1'b0;
        end
    end

    // Lengths, counts and waiter counts are written before use.
    always_ff @(posedge i_clk) begin
        if (open_commit) begin
            r_len[r_slot]  <= r_item.name_length;
            r_cnt[r_slot]  <= init_cnt;
            r_wait[r_slot] <= '0;
        end else begin
            if (cnt_we) begin
                r_cnt[id_idx] <= cnt_val;
            end
            if (wait_we) begin
                r_wait[id_idx] <= wait_val;
            end
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

>>> design/counting_semaphore_table.sv
// Top level of the counting semaphore table: stream ports, output register,
// name store and sequencer.
// Depends on csem_pkg, csem_name_ram and csem_ctrl.
//
// Usage: a request word enters on the s_axis channel; tuser carries the operation
// (open, acquire, release, close) and tdata its operands. Exactly one response
// word leaves on the m_axis channel for every request, in order.
// The block handles one request at a time: s_axis_tready is high only while the
// sequencer is idle, and drops for the whole of a request.
// Acquire, release and close pass through the exec and done states after accept,
// and the next request is taken only once the sequencer is back in idle.
// Open walks the slots one after another through a single 64-bit compare on the
// name store's one port: it checks each slot, reads the name words of each in-use
// slot of equal length, and writes the name word by word when it creates an entry.
// The response is then handed off from the done state.
// The response sits in an output register, so a new request is accepted while the
// previous response still waits. If the receiver stalls with a response pending,
// the next finished response is held in the sequencer until the register frees.
// Synchronous reset clears the sequencer, the output valid and all in-use flags;
// names, counts and waiter counts are written at open before they are read.
module counting_semaphore_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sem_id[4:0], name_word0..3[260:5], name_length[266:261],
    // initial_count[282:267], zero fill above
    input  logic [csem_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [csem_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[2:0], sem_id_out[7:3], woke_waiter[8], created[9], zero fill above
    output logic [csem_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import csem_pkg::*;

    t_item                 item;
    t_result               res;
    logic                  res_valid;
    logic                  res_ready;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_addr;
    logic [NWORD_W-1:0]    ram_wdata;
    logic [NWORD_W-1:0]    ram_rdata;
    logic                  r_m_valid;
    t_result               r_m_res;

    // Unpack the request word.
    always_comb begin
        item.func          = s_axis_tuser;
        item.sem_id        = s_axis_tdata[ID_W-1:0];
        for (int w = 0; w < NAME_WORDS; w++) begin
            item.name[w] = s_axis_tdata[ID_W + w*NWORD_W +: NWORD_W];
        end
        item.name_length   = s_axis_tdata[ID_W + NAME_WORDS*NWORD_W +: LEN_W];
        item.initial_count = s_axis_tdata[ID_W + NAME_WORDS*NWORD_W + LEN_W +: INIT_W];
    end

    csem_name_ram #(
        .DEPTH  (RAM_DEPTH),
        .WIDTH  (NWORD_W),
        .ADDR_W (RAM_AW)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    csem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    // Output register: loads whenever it is empty or being drained.
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_m_res);

endmodule

>>> design/csem_checker.sv
// Port-level checker for counting_semaphore_table, attached with bind.
// Depends on csem_pkg.
module csem_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [csem_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [csem_pkg::FUNC_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [csem_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import csem_pkg::*;

    // A stalled response word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("response word changed while stalled");

    // One request at a time: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // A wake-up is always a successful release.
    a_woke_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W + ID_W] |->
            m_axis_tdata[STATUS_W-1:0] == ST_OK && !m_axis_tdata[STATUS_W + ID_W + 1])
        else $error("wake-up reported with a bad status");

    // A created entry reports ok or a saturated count.
    a_created_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W + ID_W + 1] |->
            m_axis_tdata[STATUS_W-1:0] == ST_OK ||
            m_axis_tdata[STATUS_W-1:0] == ST_OVERFLOW)
        else $error("created entry with an unexpected status");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("response valid after reset");

endmodule

bind counting_semaphore_table csem_checker u_csem_checker (.*);
